@@ design/shcf_pkg.sv @@
// ----------------------------------------------------------------------------
// shcf_pkg
// Shared types, constants and helpers of the strip hit cluster finder.
// ----------------------------------------------------------------------------
package shcf_pkg;

  localparam int TILES_PER_VIEW      = 8;
  localparam int STRIPS_PER_DETECTOR = 256;
  localparam int REGION_WIDTH        = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [21:0] CHARGE_MAX = 22'h3FFFFF;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [8:0]  SIZE_MAX   = 9'h1FF;

  // configuration register indexes
  localparam logic [2:0] REG_FIRST_LAYER   = 3'd0;
  localparam logic [2:0] REG_WINDOW_LOW    = 3'd1;
  localparam logic [2:0] REG_WINDOW_HIGH   = 3'd2;
  localparam logic [2:0] REG_SIGMA_SCALE   = 3'd3;
  localparam logic [2:0] REG_FILTER_ENABLE = 3'd4;

  localparam logic [6:0]  FIRST_LAYER_RST   = 7'd55;
  localparam logic [9:0]  WINDOW_LOW_RST    = 10'd20;
  localparam logic [10:0] WINDOW_HIGH_RST   = 11'd45;
  localparam logic [7:0]  SIGMA_SCALE_RST   = 8'd80;
  localparam logic        FILTER_ENABLE_RST = 1'b0;

  typedef struct packed {
    logic [6:0]  first_layer;
    logic [9:0]  window_low;
    logic [10:0] window_high;
    logic [7:0]  sigma_scale;
    logic        filter_enable;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  layer;
    logic [2:0]  tile;
    logic [7:0]  strip;
    logic [9:0]  adc_max;
    logic [13:0] pedestal;
    logic [13:0] noise_rms;
    logic [9:0]  peak_sample;
  } hit_req_t;

  // qualified request handed to the clustering stage
  typedef struct packed {
    logic        is_end;
    logic        signal;
    logic [3:0]  det;
    logic [7:0]  strip;
    logic [9:0]  adc_max;
    logic [13:0] q;
  } qual_t;

  typedef struct packed {
    logic        is_summary;
    logic [3:0]  detector;
    logic [7:0]  peak_strip;
    logic [1:0]  region;
    logic [8:0]  cluster_size;
    logic [21:0] charge;
    logic [15:0] hits_seen;
    logic [15:0] signal_hits;
    logic [15:0] clusters_found;
    logic        accepted;
    logic        order_error;
    logic        last;
  } result_t;

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    sat16_inc = (v != COUNT_MAX) ? v + 16'd1 : COUNT_MAX;
  endfunction

endpackage

@@ design/shcf_qualify.sv @@
// ----------------------------------------------------------------------------
// shcf_qualify
// Input register and hit qualification: mapping, window and threshold test.
// ----------------------------------------------------------------------------
module shcf_qualify
  import shcf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  hit_req_t in_req,
  output logic     in_ready,
  output logic     out_valid,
  output qual_t    out_qual,
  input  logic     out_ready
);

  logic     a_valid;
  hit_req_t a_req;
  logic     a_move;

  logic [6:0]  lay_off;
  logic [4:0]  det_wide;
  logic        mapped;
  logic [17:0] lhs;
  logic [22:0] rhs;
  logic        pass;
  qual_t       qual_next;

  assign a_move   = !out_valid || out_ready;
  assign in_ready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_req <= in_req;
    end
  end

  always_comb begin
    lay_off  = a_req.layer - cfg.first_layer;
    det_wide = 5'(a_req.tile) + 5'(TILES_PER_VIEW) * 5'(lay_off);
    mapped   = (a_req.layer != 7'd0) && (a_req.layer >= cfg.first_layer) &&
               (lay_off < 7'd2) && (5'(a_req.tile) < 5'(TILES_PER_VIEW)) &&
               (11'(a_req.strip) < 11'(STRIPS_PER_DETECTOR)) && (det_wide <= 5'd15);
    lhs  = {a_req.adc_max, 8'd0};
    rhs  = 23'({a_req.pedestal, 4'd0}) + 23'(cfg.sigma_scale) * 23'(a_req.noise_rms);
    pass = (a_req.noise_rms != 14'd0) && (a_req.peak_sample >= cfg.window_low) &&
           (11'(a_req.peak_sample) < cfg.window_high) && (23'(lhs) >= rhs);
    qual_next.is_end  = a_req.req_type;
    qual_next.signal  = mapped && pass;
    qual_next.det     = det_wide[3:0];
    qual_next.strip   = a_req.strip;
    qual_next.adc_max = a_req.adc_max;
    qual_next.q       = {a_req.adc_max, 4'd0} - a_req.pedestal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move) begin
      out_valid <= a_valid;
    end
    if (a_move && a_valid) begin
      out_qual <= qual_next;
    end
  end

endmodule

@@ design/shcf_cluster.sv @@
// ----------------------------------------------------------------------------
// shcf_cluster
// Event state: open cluster tracking, counters, tile masks and result build.
// ----------------------------------------------------------------------------
module shcf_cluster
  import shcf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    filter_enable,
  input  logic    in_valid,
  input  qual_t   in_qual,
  output logic    in_ready,
  input  logic    room,
  output logic    push0,
  output logic    push1,
  output result_t res0,
  output result_t res1
);

  logic        open_valid,    open_valid_next;
  logic [3:0]  open_detector, open_detector_next;
  logic [7:0]  prev_strip,    prev_strip_next;
  logic [8:0]  open_size,     open_size_next;
  logic [21:0] open_charge,   open_charge_next;
  logic [9:0]  best_adc,      best_adc_next;
  logic [7:0]  best_strip,    best_strip_next;
  logic [15:0] hit_total,     hit_total_next;
  logic [15:0] signal_total,  signal_total_next;
  logic [15:0] cluster_total, cluster_total_next;
  logic [7:0]  phi_tiles_hit, phi_tiles_hit_next;
  logic [7:0]  z_tiles_hit,   z_tiles_hit_next;
  logic        seen_disorder, seen_disorder_next;

  logic        fire;
  result_t     cluster_rec;
  result_t     summary_rec;
  logic [15:0] ct_emit;
  logic [7:0]  phi_emit;
  logic [7:0]  z_emit;
  logic        same_det;
  logic        adjacent;
  logic [22:0] charge_sum;

  assign in_ready = room;
  assign fire     = in_valid && room;

  // effect of closing the open cluster
  always_comb begin
    ct_emit  = sat16_inc(cluster_total);
    phi_emit = phi_tiles_hit;
    z_emit   = z_tiles_hit;
    if (5'(open_detector) < 5'(TILES_PER_VIEW)) begin
      phi_emit[open_detector[2:0]] = 1'b1;
    end else begin
      z_emit[3'(open_detector - 4'(TILES_PER_VIEW))] = 1'b1;
    end
    cluster_rec              = '0;
    cluster_rec.detector     = open_detector;
    cluster_rec.peak_strip   = best_strip;
    cluster_rec.region       = 2'(best_strip / REGION_WIDTH);
    cluster_rec.cluster_size = open_size;
    cluster_rec.charge       = open_charge;
    summary_rec                = '0;
    summary_rec.is_summary     = 1'b1;
    summary_rec.hits_seen      = hit_total;
    summary_rec.signal_hits    = signal_total;
    summary_rec.clusters_found = open_valid ? ct_emit : cluster_total;
    summary_rec.accepted       = !filter_enable ||
                                 (open_valid ? |(phi_emit & z_emit)
                                             : |(phi_tiles_hit & z_tiles_hit));
    summary_rec.order_error    = seen_disorder;
    summary_rec.last           = 1'b1;
  end

  assign same_det   = in_qual.det == open_detector;
  assign adjacent   = 9'(in_qual.strip) == 9'(prev_strip) + 9'd1;
  assign charge_sum = 23'(open_charge) + 23'(in_qual.q);

  always_comb begin
    open_valid_next    = open_valid;
    open_detector_next = open_detector;
    prev_strip_next    = prev_strip;
    open_size_next     = open_size;
    open_charge_next   = open_charge;
    best_adc_next      = best_adc;
    best_strip_next    = best_strip;
    hit_total_next     = hit_total;
    signal_total_next  = signal_total;
    cluster_total_next = cluster_total;
    phi_tiles_hit_next = phi_tiles_hit;
    z_tiles_hit_next   = z_tiles_hit;
    seen_disorder_next = seen_disorder;
    push0 = 1'b0;
    push1 = 1'b0;
    res0  = '0;
    res1  = '0;
    if (fire) begin
      if (in_qual.is_end) begin
        push0 = 1'b1;
        if (open_valid) begin
          push1 = 1'b1;
          res0  = cluster_rec;
          res1  = summary_rec;
        end else begin
          res0 = summary_rec;
        end
        open_valid_next    = 1'b0;
        open_detector_next = '0;
        prev_strip_next    = '0;
        open_size_next     = '0;
        open_charge_next   = '0;
        best_adc_next      = '0;
        best_strip_next    = '0;
        hit_total_next     = '0;
        signal_total_next  = '0;
        cluster_total_next = '0;
        phi_tiles_hit_next = '0;
        z_tiles_hit_next   = '0;
        seen_disorder_next = 1'b0;
      end else begin
        hit_total_next = sat16_inc(hit_total);
        if (in_qual.signal) begin
          signal_total_next = sat16_inc(signal_total);
          if (open_valid && ((in_qual.det < open_detector) ||
              (same_det && (in_qual.strip < prev_strip)))) begin
            seen_disorder_next = 1'b1;
          end else if (open_valid && same_det && (in_qual.strip == prev_strip)) begin
            seen_disorder_next = seen_disorder;
          end else if (open_valid && same_det && adjacent) begin
            prev_strip_next  = in_qual.strip;
            open_size_next   = (open_size != SIZE_MAX) ? open_size + 9'd1 : SIZE_MAX;
            open_charge_next = (charge_sum > 23'(CHARGE_MAX)) ? CHARGE_MAX
                                                               : charge_sum[21:0];
            if (in_qual.adc_max > best_adc) begin
              best_adc_next   = in_qual.adc_max;
              best_strip_next = in_qual.strip;
            end
          end else begin
            if (open_valid) begin
              push0              = 1'b1;
              res0               = cluster_rec;
              res0.last          = 1'b1;
              cluster_total_next = ct_emit;
              phi_tiles_hit_next = phi_emit;
              z_tiles_hit_next   = z_emit;
            end
            open_valid_next    = 1'b1;
            open_detector_next = in_qual.det;
            prev_strip_next    = in_qual.strip;
            open_size_next     = 9'd1;
            open_charge_next   = 22'(in_qual.q);
            best_adc_next      = in_qual.adc_max;
            best_strip_next    = in_qual.strip;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_valid    <= 1'b0;
      open_detector <= '0;
      prev_strip    <= '0;
      open_size     <= '0;
      open_charge   <= '0;
      best_adc      <= '0;
      best_strip    <= '0;
      hit_total     <= '0;
      signal_total  <= '0;
      cluster_total <= '0;
      phi_tiles_hit <= '0;
      z_tiles_hit   <= '0;
      seen_disorder <= 1'b0;
    end else begin
      open_valid    <= open_valid_next;
      open_detector <= open_detector_next;
      prev_strip    <= prev_strip_next;
      open_size     <= open_size_next;
      open_charge   <= open_charge_next;
      best_adc      <= best_adc_next;
      best_strip    <= best_strip_next;
      hit_total     <= hit_total_next;
      signal_total  <= signal_total_next;
      cluster_total <= cluster_total_next;
      phi_tiles_hit <= phi_tiles_hit_next;
      z_tiles_hit   <= z_tiles_hit_next;
      seen_disorder <= seen_disorder_next;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_qual.is_end |=> !open_valid && hit_total == 16'd0 && !seen_disorder)
    else $error("event state not cleared after end of event");
  a_open_size: assert property (@(posedge clk) disable iff (rst)
    open_valid |-> open_size != 9'd0)
    else $error("open cluster with zero size");
  a_signal_le_hits: assert property (@(posedge clk) disable iff (rst)
    signal_total <= hit_total)
    else $error("signal count exceeds hit count");
  a_best_in_cluster: assert property (@(posedge clk) disable iff (rst)
    open_valid |-> best_strip <= prev_strip)
    else $error("peak strip beyond cluster end");
  a_two_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push1 |-> push0 && in_qual.is_end && res1.is_summary)
    else $error("second result outside end of event");
`endif

endmodule

@@ design/shcf_out_queue.sv @@
// ----------------------------------------------------------------------------
// shcf_out_queue
// Small result queue taking up to two records a cycle, one out per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module shcf_out_queue
  import shcf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push0,
  input  logic    push1,
  input  result_t res0,
  input  result_t res1,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       count;
  logic                  pop;

  assign out_valid = count != '0;
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room      = count <= (QPTR_W+1)'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= res0;
    end
    if (push1) begin
      mem[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push0) + QPTR_W'(push1);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + (QPTR_W+1)'(push0) + (QPTR_W+1)'(push1) - (QPTR_W+1)'(pop);
    end
  end

endmodule

@@ design/strip_hit_cluster_finder.sv @@
// ----------------------------------------------------------------------------
// strip_hit_cluster_finder
// Qualifies sorted strip hits, groups adjacent signal strips into clusters
// and reports cluster records and an end-of-event summary.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the output queue has room. Requests
// pass an input register and a qualification register; the clustering stage
// then writes its records into the output queue, from which they are taken.
// An end-of-event request with an open cluster gives two records; they go
// into a four-entry output queue that drains one record a cycle while the
// output side is ready, and requests stall only while that queue holds more
// than two records, i.e. while the output side is back-pressured.
// ----------------------------------------------------------------------------
module strip_hit_cluster_finder
  import shcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // layer[6:0] tile[9:7] strip[17:10] adc_max[27:18] pedestal[41:28]
  // noise_rms[55:42] peak_sample[65:56], zero fill
  input  logic [71:0] s_axis_tdata,
  // req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // detector[3:0] peak_strip[11:4] region[13:12] cluster_size[22:14]
  // charge[44:23] hits_seen[60:45] signal_hits[76:61] clusters_found[92:77]
  // accepted[93] order_error[94], zero fill
  output logic [95:0] m_axis_tdata,
  // is_summary
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  cfg_t     cfg;
  hit_req_t in_req;
  logic     q_valid;
  qual_t    q_qual;
  logic     q_ready;
  logic     room;
  logic     push0;
  logic     push1;
  result_t  res0;
  result_t  res1;
  result_t  out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_layer   <= FIRST_LAYER_RST;
      cfg.window_low    <= WINDOW_LOW_RST;
      cfg.window_high   <= WINDOW_HIGH_RST;
      cfg.sigma_scale   <= SIGMA_SCALE_RST;
      cfg.filter_enable <= FILTER_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_LAYER:   cfg.first_layer   <= cfg_data[6:0];
        REG_WINDOW_LOW:    cfg.window_low    <= cfg_data[9:0];
        REG_WINDOW_HIGH:   cfg.window_high   <= cfg_data[10:0];
        REG_SIGMA_SCALE:   cfg.sigma_scale   <= cfg_data[7:0];
        REG_FILTER_ENABLE: cfg.filter_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_req.req_type    = s_axis_tuser;
    in_req.layer       = s_axis_tdata[6:0];
    in_req.tile        = s_axis_tdata[9:7];
    in_req.strip       = s_axis_tdata[17:10];
    in_req.adc_max     = s_axis_tdata[27:18];
    in_req.pedestal    = s_axis_tdata[41:28];
    in_req.noise_rms   = s_axis_tdata[55:42];
    in_req.peak_sample = s_axis_tdata[65:56];
  end

  shcf_qualify u_qualify (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_req    (in_req),
    .in_ready  (s_axis_tready),
    .out_valid (q_valid),
    .out_qual  (q_qual),
    .out_ready (q_ready)
  );

  shcf_cluster u_cluster (
    .clk           (clk),
    .rst           (rst),
    .filter_enable (cfg.filter_enable),
    .in_valid      (q_valid),
    .in_qual       (q_qual),
    .in_ready      (q_ready),
    .room          (room),
    .push0         (push0),
    .push1         (push1),
    .res0          (res0),
    .res1          (res1)
  );

  shcf_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.order_error, out_res.accepted,
                         out_res.clusters_found, out_res.signal_hits, out_res.hits_seen,
                         out_res.charge, out_res.cluster_size, out_res.region,
                         out_res.peak_strip, out_res.detector};
  assign m_axis_tuser = out_res.is_summary;
  assign m_axis_tlast = out_res.last;

endmodule

@@ tb/sv/shcf_cluster_checker.sv @@
// ----------------------------------------------------------------------------
// shcf_cluster_checker
// Watches the request, record and register channels of the strip hit cluster
// finder, predicts the cluster records and event summaries each accepted
// request causes, and compares every accepted record field by field.
// ----------------------------------------------------------------------------
module shcf_cluster_checker
  import shcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          mismatch_count,
  output int          records_pending
);

  cfg_t regs;

  // open cluster and event totals
  logic        clu_open;
  logic [3:0]  clu_det;
  logic [7:0]  clu_last_strip;
  logic [8:0]  clu_size;
  logic [21:0] clu_charge;
  logic [9:0]  clu_peak_adc;
  logic [7:0]  clu_peak_strip;
  logic [15:0] n_hits;
  logic [15:0] n_signal;
  logic [15:0] n_found;
  logic [7:0]  phi_mask;
  logic [7:0]  z_mask;
  logic        disorder;

  result_t  expected_records[$];
  hit_req_t req;
  result_t  got;
  result_t  want;
  string    diffs;

  task automatic clear_event();
    clu_open = 1'b0;
    clu_det = '0;
    clu_last_strip = '0;
    clu_size = '0;
    clu_charge = '0;
    clu_peak_adc = '0;
    clu_peak_strip = '0;
    n_hits = '0;
    n_signal = '0;
    n_found = '0;
    phi_mask = '0;
    z_mask = '0;
    disorder = 1'b0;
  endtask

  task automatic close_cluster(input logic is_last);
    result_t rec;
    rec = '0;
    rec.detector = clu_det;
    rec.peak_strip = clu_peak_strip;
    rec.region = 2'((int'(clu_peak_strip) / REGION_WIDTH) % 4);
    rec.cluster_size = clu_size;
    rec.charge = clu_charge;
    rec.last = is_last;
    expected_records.insert(expected_records.size(), rec);
    if (n_found != COUNT_MAX) n_found++;
    if (int'(clu_det) < TILES_PER_VIEW) phi_mask[clu_det[2:0]] = 1'b1;
    else z_mask[3'((int'(clu_det) - TILES_PER_VIEW) % 8)] = 1'b1;
    clu_open = 1'b0;
  endtask

  task automatic start_cluster(input int det, input logic [7:0] strip, input logic [9:0] adc,
                               input int q);
    clu_open = 1'b1;
    clu_det = 4'(det);
    clu_last_strip = strip;
    clu_size = 9'd1;
    clu_charge = 22'(q);
    clu_peak_adc = adc;
    clu_peak_strip = strip;
  endtask

  task automatic predict_records(input hit_req_t r);
    result_t summary;
    int      dl;
    int      det;
    int      lhs;
    int      rhs;
    int      q;
    int      sum;
    logic    mapped;
    if (r.req_type) begin
      if (clu_open) close_cluster(1'b0);
      summary = '0;
      summary.is_summary = 1'b1;
      summary.hits_seen = n_hits;
      summary.signal_hits = n_signal;
      summary.clusters_found = n_found;
      summary.accepted = !regs.filter_enable || ((phi_mask & z_mask) != 8'd0);
      summary.order_error = disorder;
      summary.last = 1'b1;
      expected_records.insert(expected_records.size(), summary);
      clear_event();
      return;
    end
    if (n_hits != COUNT_MAX) n_hits++;
    dl = int'(r.layer) - int'(regs.first_layer);
    det = int'(r.tile) + TILES_PER_VIEW * dl;
    mapped = r.layer != 7'd0 && dl >= 0 && dl < 2 && int'(r.tile) < TILES_PER_VIEW
             && int'(r.strip) < STRIPS_PER_DETECTOR && det <= 15;
    if (!mapped) return;
    lhs = int'(r.adc_max) * 256;
    rhs = int'(r.pedestal) * 16 + int'(regs.sigma_scale) * int'(r.noise_rms);
    if (!(r.noise_rms != 14'd0 && int'(r.peak_sample) >= int'(regs.window_low)
          && int'(r.peak_sample) < int'(regs.window_high) && lhs >= rhs)) return;
    if (n_signal != COUNT_MAX) n_signal++;
    q = int'(r.adc_max) * 16 - int'(r.pedestal);
    if (!clu_open) begin
      start_cluster(det, r.strip, r.adc_max, q);
      return;
    end
    if (det < int'(clu_det) || (det == int'(clu_det) && r.strip < clu_last_strip)) begin
      disorder = 1'b1;
      return;
    end
    if (det == int'(clu_det) && r.strip == clu_last_strip) return;
    if (det == int'(clu_det) && int'(r.strip) == int'(clu_last_strip) + 1) begin
      clu_last_strip = r.strip;
      if (clu_size != SIZE_MAX) clu_size++;
      sum = int'(clu_charge) + q;
      clu_charge = (sum > int'(CHARGE_MAX)) ? CHARGE_MAX : 22'(sum);
      if (r.adc_max > clu_peak_adc) begin
        clu_peak_adc = r.adc_max;
        clu_peak_strip = r.strip;
      end
      return;
    end
    close_cluster(1'b1);
    start_cluster(det, r.strip, r.adc_max, q);
  endtask

  function automatic string field_diffs(input result_t w, input result_t g);
    string s;
    s = "";
    if (w.is_summary != g.is_summary)
      s = {s, $sformatf(" is_summary %0d/%0d", w.is_summary, g.is_summary)};
    if (w.detector != g.detector)
      s = {s, $sformatf(" detector %0d/%0d", w.detector, g.detector)};
    if (w.peak_strip != g.peak_strip)
      s = {s, $sformatf(" peak_strip %0d/%0d", w.peak_strip, g.peak_strip)};
    if (w.region != g.region)
      s = {s, $sformatf(" region %0d/%0d", w.region, g.region)};
    if (w.cluster_size != g.cluster_size)
      s = {s, $sformatf(" cluster_size %0d/%0d", w.cluster_size, g.cluster_size)};
    if (w.charge != g.charge)
      s = {s, $sformatf(" charge %0d/%0d", w.charge, g.charge)};
    if (w.hits_seen != g.hits_seen)
      s = {s, $sformatf(" hits_seen %0d/%0d", w.hits_seen, g.hits_seen)};
    if (w.signal_hits != g.signal_hits)
      s = {s, $sformatf(" signal_hits %0d/%0d", w.signal_hits, g.signal_hits)};
    if (w.clusters_found != g.clusters_found)
      s = {s, $sformatf(" clusters_found %0d/%0d", w.clusters_found, g.clusters_found)};
    if (w.accepted != g.accepted)
      s = {s, $sformatf(" accepted %0d/%0d", w.accepted, g.accepted)};
    if (w.order_error != g.order_error)
      s = {s, $sformatf(" order_error %0d/%0d", w.order_error, g.order_error)};
    if (w.last != g.last)
      s = {s, $sformatf(" last %0d/%0d", w.last, g.last)};
    return s;
  endfunction

  initial begin
    mismatch_count = 0;
    records_pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      regs.first_layer = FIRST_LAYER_RST;
      regs.window_low = WINDOW_LOW_RST;
      regs.window_high = WINDOW_HIGH_RST;
      regs.sigma_scale = SIGMA_SCALE_RST;
      regs.filter_enable = FILTER_ENABLE_RST;
      clear_event();
      expected_records.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_LAYER: regs.first_layer = cfg_data[6:0];
          REG_WINDOW_LOW: regs.window_low = cfg_data[9:0];
          REG_WINDOW_HIGH: regs.window_high = cfg_data[10:0];
          REG_SIGMA_SCALE: regs.sigma_scale = cfg_data[7:0];
          REG_FILTER_ENABLE: regs.filter_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.req_type = s_axis_tuser;
        req.layer = s_axis_tdata[6:0];
        req.tile = s_axis_tdata[9:7];
        req.strip = s_axis_tdata[17:10];
        req.adc_max = s_axis_tdata[27:18];
        req.pedestal = s_axis_tdata[41:28];
        req.noise_rms = s_axis_tdata[55:42];
        req.peak_sample = s_axis_tdata[65:56];
        predict_records(req);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.is_summary = m_axis_tuser;
        got.detector = m_axis_tdata[3:0];
        got.peak_strip = m_axis_tdata[11:4];
        got.region = m_axis_tdata[13:12];
        got.cluster_size = m_axis_tdata[22:14];
        got.charge = m_axis_tdata[44:23];
        got.hits_seen = m_axis_tdata[60:45];
        got.signal_hits = m_axis_tdata[76:61];
        got.clusters_found = m_axis_tdata[92:77];
        got.accepted = m_axis_tdata[93];
        got.order_error = m_axis_tdata[94];
        got.last = m_axis_tlast;
        if (expected_records.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("record with none expected: tuser %0d tlast %0d tdata %h",
                     m_axis_tuser, m_axis_tlast, m_axis_tdata);
        end else begin
          want = expected_records.pop_front();
          diffs = field_diffs(want, got);
          if (diffs != "") begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("record mismatch (expected/actual):%s", diffs);
          end
        end
      end
    end
    records_pending <= expected_records.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the strip hit cluster finder with directed hits and random events
// under several register settings, with random idling on both streams and
// one long output stall; the cluster checker predicts and compares records.
// ----------------------------------------------------------------------------
module tb;
  import shcf_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;

  int mismatch_count;
  int records_pending;

  // settings last written, used to shape the stimulus
  logic [6:0]  cur_first;
  logic [9:0]  cur_wlo;
  logic [10:0] cur_whi;
  logic [7:0]  cur_sigma;

  int   sent;
  int   idle_pct;
  logic quiet;
  logic held;
  int   stall_cycles;

  strip_hit_cluster_finder uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  shcf_cluster_checker cluster_chk (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .records_pending(records_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic hit_req_t mk_hit(input int layer, tile, strip, adc, ped, rms, ps);
    hit_req_t r;
    r.req_type = 1'b0;
    r.layer = 7'(layer);
    r.tile = 3'(tile);
    r.strip = 8'(strip);
    r.adc_max = 10'(adc);
    r.pedestal = 14'(ped);
    r.noise_rms = 14'(rms);
    r.peak_sample = 10'(ps);
    return r;
  endfunction

  function automatic hit_req_t noise_hit();
    hit_req_t r;
    r = mk_hit($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(2, 0) == 0) r.layer = 7'(int'(cur_first) + $urandom_range(1, 0));
    return r;
  endfunction

  function automatic hit_req_t end_req();
    hit_req_t r;
    r = noise_hit();
    r.req_type = 1'b1;
    return r;
  endfunction

  // hit on detector det that passes qualification, or fails it one way
  function automatic hit_req_t make_hit(input int det, input int strip, input bit qualify);
    hit_req_t r;
    int room;
    int rms_max;
    r = mk_hit(int'(cur_first) + det / TILES_PER_VIEW, det % TILES_PER_VIEW, strip,
               $urandom_range(1023, 200), 0, 1, 0);
    if ($urandom_range(3, 0) != 0) r.pedestal = 14'($urandom_range(int'(r.adc_max) * 16, 0));
    room = int'(r.adc_max) * 256 - int'(r.pedestal) * 16;
    rms_max = (cur_sigma == 8'd0) ? 16383 : room / int'(cur_sigma);
    if (rms_max == 0) begin
      r.pedestal = '0;
      rms_max = int'(r.adc_max) * 256 / int'(cur_sigma);
    end
    if (rms_max > 16383) rms_max = 16383;
    r.noise_rms = 14'(($urandom_range(3, 0) == 0) ? rms_max : $urandom_range(rms_max, 1));
    if (cur_whi > 11'(cur_wlo))
      r.peak_sample = 10'($urandom_range(int'(cur_whi) - 1, int'(cur_wlo)));
    else
      r.peak_sample = 10'($urandom);
    if (!qualify) begin
      case ($urandom_range(2, 0))
        0: r.noise_rms = '0;
        1: r.pedestal = 14'((int'(r.adc_max) * 16 + 1 + $urandom_range(8, 0) > 16383) ? 16383 :
                            int'(r.adc_max) * 16 + 1 + $urandom_range(8, 0));
        default: begin
          if (cur_wlo != 10'd0) r.peak_sample = 10'($urandom_range(int'(cur_wlo) - 1, 0));
          else if (cur_whi <= 11'd1023) r.peak_sample = 10'($urandom_range(1023, int'(cur_whi)));
          else r.noise_rms = '0;
        end
      endcase
    end
    return r;
  endfunction

  task automatic put_req(input hit_req_t r);
    if (!quiet && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    s_axis_tuser <= r.req_type;
    s_axis_tdata <= {6'b0, r.peak_sample, r.noise_rms, r.pedestal, r.adc_max, r.strip,
                     r.tile, r.layer};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input int first, wlo, whi, sigma, filt);
    cur_first = 7'(first);
    cur_wlo = 10'(wlo);
    cur_whi = 11'(whi);
    cur_sigma = 8'(sigma);
    cfg_we <= 1'b1;
    cfg_index <= REG_FIRST_LAYER;
    cfg_data <= 11'(first);
    @(posedge clk);
    cfg_index <= REG_WINDOW_LOW;
    cfg_data <= 11'(wlo);
    @(posedge clk);
    cfg_index <= REG_WINDOW_HIGH;
    cfg_data <= 11'(whi);
    @(posedge clk);
    cfg_index <= REG_SIGMA_SCALE;
    cfg_data <= 11'(sigma);
    @(posedge clk);
    cfg_index <= REG_FILTER_ENABLE;
    cfg_data <= 11'(filt);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sorted event with runs, gaps, detector changes, repeats and some disorder
  task automatic run_event(input int n_hits);
    int det;
    int strip;
    int pick;
    int advance;
    hit_req_t r;
    det = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(15, 0);
    strip = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(200, 0);
    for (int i = 0; i < n_hits; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        r = noise_hit();
      end else if (pick < 12) begin
        r = make_hit(det, $urandom_range(strip, 0), 1'b1);
      end else if (pick < 14 && det > 0) begin
        r = make_hit($urandom_range(det - 1, 0), $urandom_range(255, 0), 1'b1);
      end else begin
        advance = (pick < 70) ? 1 : (pick < 88) ? $urandom_range(5, 2) : 0;
        if (advance == 0 || strip + advance > 255) begin
          if (det < 15) begin
            det++;
            strip = $urandom_range(30, 0);
          end
        end else begin
          strip += advance;
        end
        r = make_hit(det, strip, $urandom_range(9, 0) != 0);
      end
      put_req(r);
    end
    put_req(end_req());
  endtask

  task automatic run_phase(input int n_items);
    int start;
    start = sent;
    while (sent - start < n_items) begin
      if ($urandom_range(9, 0) == 0) begin
        repeat ($urandom_range(10, 1)) put_req(noise_hit());
        put_req(end_req());
      end else begin
        run_event($urandom_range(25, 0));
      end
    end
  endtask

  // output side: random stalls, one long hold-off once traffic is flowing
  initial begin
    m_axis_tready = 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sent >= 150) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (quiet || $urandom_range(99, 0) >= idle_pct) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(16, 1)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or record moved for %0d cycles", stall_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    hit_req_t r;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_cycles = 0;
    sent = 0;
    idle_pct = 20;
    quiet = 1'b0;
    cur_first = FIRST_LAYER_RST;
    cur_wlo = WINDOW_LOW_RST;
    cur_whi = WINDOW_HIGH_RST;
    cur_sigma = SIGMA_SCALE_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings
    put_req(end_req());
    put_req(mk_hit(0, 0, 0, 1023, 0, 1, 30));
    put_req(mk_hit(55, 0, 0, 1023, 0, 1, 20));
    put_req(mk_hit(55, 0, 1, 100, 1100, 100, 44));
    put_req(mk_hit(55, 0, 1, 900, 0, 1, 30));
    put_req(mk_hit(55, 0, 0, 900, 0, 1, 30));
    put_req(mk_hit(55, 0, 2, 100, 1101, 100, 30));
    put_req(mk_hit(55, 0, 3, 1023, 0, 1, 45));
    put_req(mk_hit(55, 0, 4, 1023, 0, 0, 30));
    put_req(mk_hit(55, 0, 5, 1023, 0, 1, 19));
    put_req(mk_hit(55, 0, 6, 1023, 16363, 1, 30));
    put_req(mk_hit(55, 0, 7, 1023, 0, 1, 30));
    put_req(mk_hit(56, 7, 255, 1023, 0, 3000, 30));
    put_req(mk_hit(57, 1, 10, 1023, 0, 1, 30));
    put_req(mk_hit(54, 1, 10, 1023, 0, 1, 30));
    put_req(end_req());
    settle();

    // tile coincidence filter: one event passes, one fails
    set_config(FIRST_LAYER_RST, WINDOW_LOW_RST, WINDOW_HIGH_RST, SIGMA_SCALE_RST, 1);
    put_req(mk_hit(55, 3, 10, 500, 0, 1, 30));
    put_req(mk_hit(56, 3, 10, 500, 0, 1, 30));
    put_req(end_req());
    put_req(mk_hit(55, 2, 20, 500, 0, 1, 30));
    put_req(mk_hit(56, 4, 20, 500, 0, 1, 30));
    put_req(end_req());
    settle();

    set_config(1, 0, 1024, 0, 1);
    idle_pct = 25;
    run_phase(300);
    settle();

    // one long event of repeated strips
    set_config(126, 1023, 1024, 255, 0);
    idle_pct = 0;
    r = make_hit(0, 7, 1'b1);
    repeat (40) put_req(r);
    put_req(end_req());
    idle_pct = 15;
    run_phase(200);
    settle();

    // empty window: nothing qualifies
    set_config(64, 1023, 0, 0, 1);
    idle_pct = 30;
    run_phase(60);
    settle();

    set_config($urandom_range(125, 2), $urandom_range(400, 0), $urandom_range(1024, 401),
               $urandom_range(255, 0), $urandom_range(1, 0));
    idle_pct = 35;
    run_phase(300);
    settle();

    quiet = 1'b1;
    idle_pct = 0;
    set_config($urandom_range(125, 2), $urandom_range(400, 0), $urandom_range(1024, 401),
               $urandom_range(255, 0), $urandom_range(1, 0));
    run_phase(250);
    settle();

    if (mismatch_count == 0 && records_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
design/shcf_pkg.sv
design/shcf_qualify.sv
design/shcf_cluster.sv
design/shcf_out_queue.sv
design/strip_hit_cluster_finder.sv
tb/sv/shcf_cluster_checker.sv
tb/sv/tb.sv
